[hdl/tss_pkg.sv]
// ============================================================================
// tss_pkg: shared types and constants of the tempo step sequencer
// Field widths, command and note codes, divider constants and the
// request/response structs between the sequencer and its divider.
// ============================================================================
package tss_pkg;

  // Sequencer size and time base
  localparam int STEP_COUNT    = 8;
  localparam int MS_PER_MINUTE = 60000;
  localparam int STEP_W        = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;

  // Item field widths
  localparam int CMD_W        = 2;
  localparam int SAMPLE_W     = 10;
  localparam int STEP_LINES_W = 8;
  localparam int CUR_STEP_W   = 3;
  localparam int TEMPO_W      = 17;
  localparam int NOTE_W       = 3;
  localparam int PERIOD_W     = 14;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TEMPO    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DIVISION = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

  // Note codes
  localparam logic [NOTE_W-1:0] NOTE_WHOLE     = 3'd0;
  localparam logic [NOTE_W-1:0] NOTE_HALF      = 3'd1;
  localparam logic [NOTE_W-1:0] NOTE_QUARTER   = 3'd2;
  localparam logic [NOTE_W-1:0] NOTE_EIGHTH    = 3'd3;
  localparam logic [NOTE_W-1:0] NOTE_SIXTEENTH = 3'd4;
  localparam logic [NOTE_W-1:0] NOTE_THIRTY2ND = 3'd5;
  localparam int                NOTE_MAX       = 5;

  // Tempo scaling: Q.8 tempo = sample * 75, floor at 20 BPM
  localparam logic [TEMPO_W-1:0] TEMPO_GAIN = 17'd75;
  localparam logic [TEMPO_W-1:0] TEMPO_MIN  = 17'd5120;

  // Period divider: numerator is ms per minute * 4 beats * 256 (Q.8)
  localparam int NUM_VAL    = MS_PER_MINUTE * 1024;
  localparam int NUM_W      = $clog2(NUM_VAL + 1);
  localparam int DEN_W      = TEMPO_W + NOTE_MAX;
  localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
  localparam int PERIOD_MAX = 16383;

  // Reset values of the sequencer state
  localparam logic [NOTE_W-1:0]   NOTE_RESET   = NOTE_QUARTER;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 14'd3000;

  typedef struct packed {
    logic             start;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] quotient;
  } div_rsp_t;

endpackage

[hdl/tss_if.sv]
// ============================================================================
// tss_if: item channels of the tempo step sequencer
// Valid/ready channels for command items and for result items.
// ============================================================================
interface tss_in_if import tss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output command, output sample, input ready);
  modport sink   (input valid, input command, input sample, output ready);
endinterface

interface tss_out_if import tss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STEP_LINES_W-1:0] step_lines;
  logic [CUR_STEP_W-1:0]   current_step;
  logic [TEMPO_W-1:0]      tempo_fixed;
  logic [NOTE_W-1:0]       note_code;
  logic [PERIOD_W-1:0]     period_ms;

  modport source (output valid, output step_lines, output current_step,
                  output tempo_fixed, output note_code, output period_ms,
                  input ready);
  modport sink   (input valid, input step_lines, input current_step,
                  input tempo_fixed, input note_code, input period_ms,
                  output ready);
endinterface

[hdl/tss_div.sv]
// ============================================================================
// tss_div: bit-serial period divider
// Restoring division of the fixed numerator by the shifted tempo, one
// quotient bit per cycle, result saturated to the period width.
// ============================================================================
module tss_div import tss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r,  busy_nxt;
  logic                 done_r,  done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r,   cnt_nxt;
  logic [DEN_W-1:0]     den_r,   den_nxt;
  logic [DEN_W-1:0]     rem_r,   rem_nxt;
  logic [NUM_W-1:0]     quot_r,  quot_nxt;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           fits;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem_r, quot_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = req.den;
      rem_nxt  = '0;
      quot_nxt = NUM_W'(NUM_VAL);
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot_nxt = {quot_r[NUM_W-2:0], fits};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  // Clamp the quotient to the widest period
  assign rsp.done     = done_r;
  assign rsp.quotient = (quot_r > NUM_W'(PERIOD_MAX)) ? PERIOD_W'(PERIOD_MAX)
                                                      : quot_r[PERIOD_W-1:0];

endmodule

[hdl/tempo_step_sequencer_top.sv]
// ============================================================================
// tempo_step_sequencer_top: tempo / note-division step sequencer
// Tempo and division knob samples plus a millisecond tick drive a one-hot
// step output; each command item yields one result item with the state.
// ============================================================================
// Path: tempo samples, ticks and unused codes go from accept through the
//   result state to the output register; a division sample also waits in the
//   divide state until the bit-serial period divider is done.
// Throughput: one item at a time; a new item is taken once the previous one
//   has reached the output register, which may still be waiting to drain.
// Reset (rst_n, synchronous, active low): 20 BPM, quarter note, 3000 ms
//   period, step 0, tick count 0, no result pending.
module tempo_step_sequencer_top import tss_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  tss_in_if.sink           in_item,
  tss_out_if.source        out_item
);

  // Sequencer control
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIV    = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEP_COUNT - 1);

  // Division bands: an exact edge belongs to the upper band
  localparam logic [SAMPLE_W-1:0] BAND_HALF      = 10'd170;
  localparam logic [SAMPLE_W-1:0] BAND_QUARTER   = 10'd340;
  localparam logic [SAMPLE_W-1:0] BAND_EIGHTH    = 10'd510;
  localparam logic [SAMPLE_W-1:0] BAND_SIXTEENTH = 10'd680;
  localparam logic [SAMPLE_W-1:0] BAND_THIRTY2ND = 10'd850;

  state_t state_r, state_nxt;

  // Sequencer state
  logic [TEMPO_W-1:0]  tempo_r,  tempo_nxt;
  logic [NOTE_W-1:0]   note_r,   note_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [PERIOD_W-1:0] tick_r,   tick_nxt;
  logic [STEP_W-1:0]   step_r,   step_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic [STEP_LINES_W-1:0] out_lines_r, out_lines_nxt;
  logic [CUR_STEP_W-1:0]   out_step_r,  out_step_nxt;
  logic [TEMPO_W-1:0]      out_tempo_r, out_tempo_nxt;
  logic [NOTE_W-1:0]       out_note_r,  out_note_nxt;
  logic [PERIOD_W-1:0]     out_period_r, out_period_nxt;

  logic               in_fire;
  logic               out_free;
  logic [TEMPO_W-1:0] tempo_prod;
  logic [NOTE_W-1:0]  band_note;
  logic [PERIOD_W-1:0] tick_inc;
  logic [3:0]         step_ext;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_item.ready = (state_r == ST_IDLE);
  assign in_fire       = in_item.valid && in_item.ready;
  assign out_free      = !out_valid_r || out_item.ready;

  // Tempo in Q.8: sample * 75 / 256 BPM
  assign tempo_prod = TEMPO_W'(in_item.sample) * TEMPO_GAIN;
  assign tick_inc   = tick_r + 1'b1;
  assign step_ext   = 4'(step_r);

  // Pick the note length from the division knob
  always_comb begin
    priority if (in_item.sample < BAND_HALF)      band_note = NOTE_WHOLE;
    else if     (in_item.sample < BAND_QUARTER)   band_note = NOTE_HALF;
    else if     (in_item.sample < BAND_EIGHTH)    band_note = NOTE_QUARTER;
    else if     (in_item.sample < BAND_SIXTEENTH) band_note = NOTE_EIGHTH;
    else if     (in_item.sample < BAND_THIRTY2ND) band_note = NOTE_SIXTEENTH;
    else                                          band_note = NOTE_THIRTY2ND;
  end

  always_comb begin
    state_nxt      = state_r;
    tempo_nxt      = tempo_r;
    note_nxt       = note_r;
    period_nxt     = period_r;
    tick_nxt       = tick_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_item.ready;
    out_lines_nxt  = out_lines_r;
    out_step_nxt   = out_step_r;
    out_tempo_nxt  = out_tempo_r;
    out_note_nxt   = out_note_r;
    out_period_nxt = out_period_r;
    div_req.start  = 1'b0;
    div_req.den    = DEN_W'(tempo_r) << band_note;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RESULT;
          priority if (in_item.command == CMD_TEMPO) begin
            // Hold the tempo at or above 20 BPM
            tempo_nxt = (tempo_prod <= TEMPO_MIN) ? TEMPO_MIN : tempo_prod;
          end else if (in_item.command == CMD_DIVISION) begin
            // Store the note and launch the period division
            note_nxt      = band_note;
            div_req.start = 1'b1;
            state_nxt     = ST_DIV;
          end else if (in_item.command == CMD_TICK) begin
            // Count the tick; advance the step once the period is used up
            if (tick_inc >= period_r) begin
              tick_nxt = '0;
              step_nxt = (step_r == STEP_LAST) ? '0 : step_r + 1'b1;
            end else begin
              tick_nxt = tick_inc;
            end
          end else begin
            // Unused code: report the state unchanged
            tick_nxt = tick_r;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          period_nxt = div_rsp.quotient;
          state_nxt  = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // Load the output register once the previous result has left
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_lines_nxt  = STEP_LINES_W'(16'd1 << step_ext);
          out_step_nxt   = step_ext[CUR_STEP_W-1:0];
          out_tempo_nxt  = tempo_r;
          out_note_nxt   = note_r;
          out_period_nxt = period_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tempo_r     <= TEMPO_MIN;
      note_r      <= NOTE_RESET;
      period_r    <= PERIOD_RESET;
      tick_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tempo_r     <= tempo_nxt;
      note_r      <= note_nxt;
      period_r    <= period_nxt;
      tick_r      <= tick_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_lines_r  <= out_lines_nxt;
    out_step_r   <= out_step_nxt;
    out_tempo_r  <= out_tempo_nxt;
    out_note_r   <= out_note_nxt;
    out_period_r <= out_period_nxt;
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.step_lines   = out_lines_r;
  assign out_item.current_step = out_step_r;
  assign out_item.tempo_fixed  = out_tempo_r;
  assign out_item.note_code    = out_note_r;
  assign out_item.period_ms    = out_period_r;

endmodule

[hdl/tss_checker.sv]
// ============================================================================
// tss_checker: port-level checks of the tempo step sequencer
// Watches the item channels and flags results that break the block's rules.
// ============================================================================
module tss_checker import tss_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [STEP_LINES_W-1:0] step_lines,
  input logic [TEMPO_W-1:0]      tempo_fixed,
  input logic [NOTE_W-1:0]       note_code,
  input logic [PERIOD_W-1:0]     period_ms
);

  // A pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(step_lines) &&
      $stable(tempo_fixed) && $stable(period_ms))
    else $error("result item changed while stalled");

  // One item at a time: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accept");

  // At most one gate line is high
  a_gate_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(step_lines))
    else $error("more than one gate line high");

  // Tempo never below 20 BPM
  a_tempo_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> tempo_fixed >= TEMPO_MIN)
    else $error("tempo below floor");

  // Note code stays within the division table
  a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> note_code <= NOTE_W'(NOTE_MAX))
    else $error("note code out of range");

endmodule

bind tempo_step_sequencer_top tss_checker u_tss_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_item.valid),
  .in_ready    (in_item.ready),
  .out_valid   (out_item.valid),
  .out_ready   (out_item.ready),
  .step_lines  (out_item.step_lines),
  .tempo_fixed (out_item.tempo_fixed),
  .note_code   (out_item.note_code),
  .period_ms   (out_item.period_ms)
);
